@@ hdl/ped_pkg.sv @@
// shared constants and register codes for the particle euler drag step block
package ped_pkg;

    // default datapath shape
    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TAG_WIDTH_DEF     = 24;

    // time step is always an unsigned fraction of this many bits
    localparam int DT_BITS = 32;

    // configuration port
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_TIME     = 2'd0,
        REG_FLUID_DENSITY = 2'd1,
        REG_GRAVITY_ACCEL = 2'd2
    } cfg_reg_t;

    // reset values: dt about 1e-4 s, rho 1.0, g -9.8 (in tenths)
    localparam logic [DT_BITS-1:0] STEP_TIME_RESET = 32'd429497;
    localparam longint GRAVITY_TENTHS = 98;

    // status bits in the result tuser
    localparam int USER_GROUNDED  = 0;
    localparam int USER_SATURATED = 1;
    localparam int USER_ZERO_MASS = 2;
    localparam int USER_W         = 3;

endpackage

@@ hdl/particle_euler_drag_step.sv @@
// explicit euler step with linear drag: one particle per beat, fully pipelined
// a beat passes stage a, stage b, the divider, stages e and f, then the output register;
// the restoring divider for rho*area/mass takes one quotient bit per stage, VALUE_WIDTH stages
// throughput: one beat per cycle; s_tready drops only while the output skid holds a beat
// reset: aresetn low clears all valid bits and loads dt, rho and g with their defaults
// config writes take effect on the next edge and must only happen while the pipe is empty
module particle_euler_drag_step #(
    parameter int VALUE_WIDTH   = ped_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = ped_pkg::FRACTION_BITS_DEF,
    parameter int TAG_WIDTH     = ped_pkg::TAG_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // config write port
    input  logic                                   cfg_wr_en,
    input  logic [ped_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [((VALUE_WIDTH > ped_pkg::DT_BITS) ? VALUE_WIDTH
                   : ped_pkg::DT_BITS)-1:0]        cfg_wdata,
    // particle beats in
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: particle_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, drag_area, body_mass
    input  logic [((TAG_WIDTH + 8*VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // results out
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: tag_out, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [((TAG_WIDTH + 6*VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    // tuser: grounded, saturated, zero_mass
    output logic [ped_pkg::USER_W-1:0]             m_tuser
);
    import ped_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int FB     = FRACTION_BITS;
    localparam int TW     = TAG_WIDTH;
    localparam int DT     = DT_BITS;
    localparam int PM_W   = DT + 1 + VW;      // dt * value product
    localparam int POS_W  = VW + 2;           // position sum
    localparam int DP_W   = 2*VW + 1;         // vel * decay product
    localparam int SHR_W  = DP_W - FB - 1;    // drag term after the shift
    localparam int VSUM_W = 2*VW + 3;         // velocity sum

    localparam longint G_MAG = ((GRAVITY_TENTHS << FB) + 5) / 10;
    localparam logic [VW-1:0] RHO_RESET  = VW'(64'd1 << FB);
    localparam logic [VW-1:0] GRAV_RESET = VW'(-G_MAG);

    localparam logic signed [POS_W-1:0]  PMAX = {{(POS_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  PMIN = {{(POS_W-VW+1){1'b1}}, {(VW-1){1'b0}}};
    localparam logic signed [VSUM_W-1:0] VMAX = {{(VSUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [VSUM_W-1:0] VMIN = {{(VSUM_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

    // data carried alongside the divider and drag stages
    typedef struct packed {
        logic [TW-1:0]        tag;
        logic [2:0][VW-1:0]   vel;
        logic [2:0][VW-1:0]   npos;
        logic                 grounded;
        logic                 pos_sat;
        logic                 zmass;
        logic                 ovf;
    } side_t;

    typedef struct packed {
        logic [TW-1:0]        tag;
        logic [2:0][VW-1:0]   npos;
        logic [2:0][VW-1:0]   nvel;
        logic                 grounded;
        logic                 sat;
        logic                 zmass;
    } res_t;

    // configuration registers
    logic [DT-1:0]        step_time_reg;
    logic [VW-1:0]        rho_reg;
    logic [VW-1:0]        grav_reg;
    logic signed [VW:0]   gterm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= STEP_TIME_RESET;
            rho_reg       <= RHO_RESET;
            grav_reg      <= GRAV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_STEP_TIME:     step_time_reg <= cfg_wdata[DT-1:0];
                REG_FLUID_DENSITY: rho_reg       <= cfg_wdata[VW-1:0];
                REG_GRAVITY_ACCEL: grav_reg      <= cfg_wdata[VW-1:0];
                default: begin
                end
            endcase
        end
    end

    // gravity velocity increment dt*g, floored, follows the config registers
    logic signed [PM_W-1:0] gprod;
    assign gprod = PM_W'($signed({1'b0, step_time_reg})) * PM_W'($signed(grav_reg));

    always_ff @(posedge aclk) begin
        gterm_reg <= $signed(gprod[PM_W-1:DT]);
    end

    // pipeline advance and output skid
    logic  pipe_en;
    logic  out_valid_reg, skid_valid_reg;
    res_t  out_reg, skid_reg, res_next;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    // input unpack
    logic [TW-1:0]      in_tag;
    logic [2:0][VW-1:0] in_pos, in_vel;
    logic [VW-1:0]      in_area, in_mass;

    always_comb begin
        in_tag = s_tdata[TW-1:0];
        for (int i = 0; i < 3; i++) begin
            in_pos[i] = s_tdata[TW + i*VW +: VW];
            in_vel[i] = s_tdata[TW + (3 + i)*VW +: VW];
        end
        in_area = s_tdata[TW + 6*VW +: VW];
        in_mass = s_tdata[TW + 7*VW +: VW];
    end

    // stage a: dt*vel for the moves and rho*area for the drag numerator
    logic                   a_valid_reg;
    logic [TW-1:0]          a_tag_reg;
    logic [2:0][VW-1:0]     a_pos_reg, a_vel_reg;
    logic [VW-1:0]          a_mass_reg;
    logic [2:0][PM_W-1:0]   a_pmove_reg;
    logic [2*VW-1:0]        a_rho_area_reg;
    logic [2:0][PM_W-1:0]   a_pmove_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_pmove_next[i] = PM_W'($signed({1'b0, step_time_reg}))
                            * PM_W'($signed(in_vel[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= s_tvalid;
        end
        if (pipe_en) begin
            a_tag_reg      <= in_tag;
            a_pos_reg      <= in_pos;
            a_vel_reg      <= in_vel;
            a_mass_reg     <= in_mass;
            a_pmove_reg    <= a_pmove_next;
            a_rho_area_reg <= (2*VW)'(rho_reg) * (2*VW)'(in_area);
        end
    end

    // stage b: new positions, ground test, quotient overflow test, divider load
    logic                     dv_valid_reg [VW+1];
    side_t                    dv_side_reg  [VW+1];
    logic [VW-1:0]            dv_rem_reg   [VW+1];
    logic [VW-1:0]            dv_lq_reg    [VW+1];
    logic [VW-1:0]            dv_mass_reg  [VW+1];
    side_t                    b_side_next;

    always_comb begin
        logic signed [POS_W-1:0] psum;
        logic signed [VW:0]      pstep;
        b_side_next.tag      = a_tag_reg;
        b_side_next.vel      = a_vel_reg;
        b_side_next.pos_sat  = 1'b0;
        b_side_next.grounded = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pstep = $signed(a_pmove_reg[i][PM_W-1:DT]);
            psum  = $signed({{2{a_pos_reg[i][VW-1]}}, a_pos_reg[i]})
                  + $signed({pstep[VW], pstep});
            if (psum > PMAX) begin
                b_side_next.npos[i] = PMAX[VW-1:0];
                b_side_next.pos_sat = 1'b1;
            end else if (psum < PMIN) begin
                b_side_next.npos[i] = PMIN[VW-1:0];
                b_side_next.pos_sat = 1'b1;
            end else begin
                b_side_next.npos[i] = psum[VW-1:0];
            end
            // clamping keeps sign and zero, so the wide sum decides the ground test
            if (i == 2) begin
                b_side_next.grounded = psum[POS_W-1] || (psum == '0);
            end
        end
        b_side_next.zmass = (a_mass_reg == '0);
        b_side_next.ovf   = (a_rho_area_reg[2*VW-1:VW] >= a_mass_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            dv_valid_reg[0] <= a_valid_reg;
        end
        if (pipe_en) begin
            dv_side_reg[0] <= b_side_next;
            dv_rem_reg[0]  <= a_rho_area_reg[2*VW-1:VW];
            dv_lq_reg[0]   <= a_rho_area_reg[VW-1:0];
            dv_mass_reg[0] <= a_mass_reg;
        end
    end

    // restoring divider, one quotient bit per stage shifted into the low word
    for (genvar k = 1; k <= VW; k++) begin : g_div
        logic [VW:0] trial;
        logic [VW:0] diff;
        logic        take;

        assign trial = {dv_rem_reg[k-1], dv_lq_reg[k-1][VW-1]};
        assign diff  = trial - {1'b0, dv_mass_reg[k-1]};
        assign take  = (trial >= {1'b0, dv_mass_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k] <= 1'b0;
            end else if (pipe_en) begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
            if (pipe_en) begin
                dv_side_reg[k] <= dv_side_reg[k-1];
                dv_rem_reg[k]  <= take ? diff[VW-1:0] : trial[VW-1:0];
                dv_lq_reg[k]   <= {dv_lq_reg[k-1][VW-2:0], take};
                dv_mass_reg[k] <= dv_mass_reg[k-1];
            end
        end
    end

    // stage e: clamp the drag coefficient and scale it by dt
    logic              e_valid_reg;
    side_t             e_side_reg;
    logic [VW+DT-1:0]  e_prod_reg;
    logic [VW-1:0]     coef;

    assign coef = dv_side_reg[VW].ovf ? {VW{1'b1}} : dv_lq_reg[VW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            e_valid_reg <= dv_valid_reg[VW];
        end
        if (pipe_en) begin
            e_side_reg <= dv_side_reg[VW];
            e_prod_reg <= (VW+DT)'(coef) * (VW+DT)'(step_time_reg);
        end
    end

    // stage f: drag products vel * decay
    logic                  f_valid_reg;
    side_t                 f_side_reg;
    logic [2:0][DP_W-1:0]  f_dprod_reg;
    logic [2:0][DP_W-1:0]  f_dprod_next;
    logic [VW-1:0]         decay;

    assign decay = e_prod_reg[VW+DT-1:DT];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_dprod_next[i] = DP_W'($signed(e_side_reg.vel[i]))
                            * DP_W'($signed({1'b0, decay}));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            f_valid_reg <= e_valid_reg;
        end
        if (pipe_en) begin
            f_side_reg  <= e_side_reg;
            f_dprod_reg <= f_dprod_next;
        end
    end

    // final velocities, clamping and status
    always_comb begin
        logic signed [VSUM_W-1:0] vsum;
        logic signed [SHR_W-1:0]  drag;
        logic [VW-1:0]            vi;
        logic                     vel_sat;
        vel_sat = 1'b0;
        res_next.tag      = f_side_reg.tag;
        res_next.npos     = f_side_reg.npos;
        res_next.grounded = f_side_reg.grounded;
        res_next.zmass    = f_side_reg.zmass;
        for (int i = 0; i < 3; i++) begin
            vi   = f_side_reg.vel[i];
            drag = $signed(f_dprod_reg[i][DP_W-1:FB+1]);
            vsum = $signed({{(VSUM_W-VW){vi[VW-1]}}, vi})
                 - $signed({{(VSUM_W-SHR_W){drag[SHR_W-1]}}, drag});
            if (i == 2) begin
                vsum = vsum + $signed({{(VSUM_W-VW-1){gterm_reg[VW]}}, gterm_reg});
            end
            if (vsum > VMAX) begin
                res_next.nvel[i] = VMAX[VW-1:0];
                vel_sat          = 1'b1;
            end else if (vsum < VMIN) begin
                res_next.nvel[i] = VMIN[VW-1:0];
                vel_sat          = 1'b1;
            end else begin
                res_next.nvel[i] = vsum[VW-1:0];
            end
        end
        priority if (f_side_reg.grounded) begin
            res_next.nvel = '0;
            res_next.sat  = f_side_reg.pos_sat;
        end else if (f_side_reg.zmass) begin
            res_next.nvel = f_side_reg.vel;
            res_next.sat  = f_side_reg.pos_sat;
        end else begin
            res_next.sat  = f_side_reg.pos_sat || f_side_reg.ovf || vel_sat;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (f_valid_reg && pipe_en) begin
                out_reg <= res_next;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg) begin
            if (f_valid_reg && pipe_en) begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end
        end else if (f_valid_reg && pipe_en) begin
            skid_reg       <= res_next;
            skid_valid_reg <= 1'b1;
        end
    end

    // output pack
    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[TW-1:0] = out_reg.tag;
        for (int i = 0; i < 3; i++) begin
            m_tdata[TW + i*VW +: VW]       = out_reg.npos[i];
            m_tdata[TW + (3 + i)*VW +: VW] = out_reg.nvel[i];
        end
        m_tuser = '0;
        m_tuser[USER_GROUNDED]  = out_reg.grounded;
        m_tuser[USER_SATURATED] = out_reg.sat;
        m_tuser[USER_ZERO_MASS] = out_reg.zmass;
    end

    // the skid entry is only ever filled behind a waiting output beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    // an accepted beat always lands in the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> a_valid_reg)
        else $error("accepted beat lost at pipeline entry");

    // without quotient overflow the final remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_valid_reg[VW] && !dv_side_reg[VW].ovf) |-> (dv_rem_reg[VW] < dv_mass_reg[VW]))
        else $error("divider remainder out of range");

    // a grounded result carries zero velocities
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.grounded) |-> (out_reg.nvel == '0))
        else $error("grounded result with nonzero velocity");

endmodule

@@ dv/particle_euler_drag_step_test.sv @@
// self-checking stream testbench for the particle euler drag step block
module particle_euler_drag_step_test;
    import ped_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 330;
    localparam int LONG_HOLD      = 200;

    localparam longint WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint WORD_MIN = -WORD_MAX - 1;

    // one particle beat, particle_index in the lowest bits
    typedef struct packed {
        logic [31:0] body_mass;
        logic [31:0] drag_area;
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic [23:0] particle_index;
    } particle_t;

    // one result beat as {m_tuser, m_tdata}
    typedef struct packed {
        logic        zero_mass;
        logic        saturated;
        logic        grounded;
        logic [31:0] new_vel_z;
        logic [31:0] new_vel_y;
        logic [31:0] new_vel_x;
        logic [31:0] new_pos_z;
        logic [31:0] new_pos_y;
        logic [31:0] new_pos_x;
        logic [23:0] tag_out;
    } motion_t;

    typedef struct {
        particle_t item;
        bit        typed;
        motion_t   result;
    } stim_row_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]     cfg_addr  = REG_STEP_TIME;
    logic [31:0]               cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [$bits(particle_t)-1:0] s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    // tag_out, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    logic [215:0]              m_tdata;
    // grounded, saturated, zero_mass
    logic [USER_W-1:0]         m_tuser;

    // local copy of the registers
    logic [31:0] cfg_dt  = STEP_TIME_RESET;
    logic [31:0] cfg_rho = 32'h0001_0000;
    logic [31:0] cfg_g   = -32'sd642253;

    motion_t   pending_motion[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        result_count   = 0;
    int        send_gap_max   = 18;
    int        recv_gap_max   = 18;
    int        hold_off_cycles = 0;

    logic [31:0] phase_dt[PHASE_COUNT];
    logic [31:0] phase_rho[PHASE_COUNT];
    logic [31:0] phase_g[PHASE_COUNT];

    particle_euler_drag_step i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic longint clamp_word(longint x);
        if (x > WORD_MAX) return WORD_MAX;
        if (x < WORD_MIN) return WORD_MIN;
        return x;
    endfunction

    // expected result of one euler step under the current registers
    function automatic motion_t advance_particle(particle_t p);
        motion_t   r;
        longint    dt_s, g_s, raw;
        longint    pos_in[3], vel_in[3], pos_out[3], vel_out[3];
        bit [63:0] coef, decay;
        bit        sat;
        dt_s = longint'({32'd0, cfg_dt});
        g_s  = longint'($signed(cfg_g));
        pos_in[0] = longint'($signed(p.pos_x));
        pos_in[1] = longint'($signed(p.pos_y));
        pos_in[2] = longint'($signed(p.pos_z));
        vel_in[0] = longint'($signed(p.vel_x));
        vel_in[1] = longint'($signed(p.vel_y));
        vel_in[2] = longint'($signed(p.vel_z));
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            raw = pos_in[i] + ((dt_s * vel_in[i]) >>> 32);
            pos_out[i] = clamp_word(raw);
            if (pos_out[i] != raw) sat = 1'b1;
        end
        r.grounded  = (pos_out[2] <= 0);
        r.zero_mass = (p.body_mass == '0);
        if (r.grounded) begin
            for (int i = 0; i < 3; i++) vel_out[i] = 0;
        end else if (r.zero_mass) begin
            for (int i = 0; i < 3; i++) vel_out[i] = vel_in[i];
        end else begin
            // drag coefficient rho*area/mass, clamped to one word
            coef = (64'(cfg_rho) * 64'(p.drag_area)) / 64'(p.body_mass);
            if (coef > 64'hFFFF_FFFF) begin
                coef = 64'hFFFF_FFFF;
                sat  = 1'b1;
            end
            decay = (coef * 64'(cfg_dt)) >> 32;
            for (int i = 0; i < 3; i++) begin
                raw = vel_in[i] - ((vel_in[i] * longint'(decay)) >>> 17);
                if (i == 2) raw = raw + ((dt_s * g_s) >>> 32);
                vel_out[i] = clamp_word(raw);
                if (vel_out[i] != raw) sat = 1'b1;
            end
        end
        r.saturated = sat;
        r.tag_out   = p.particle_index;
        r.new_pos_x = 32'(pos_out[0]);
        r.new_pos_y = 32'(pos_out[1]);
        r.new_pos_z = 32'(pos_out[2]);
        r.new_vel_x = 32'(vel_out[0]);
        r.new_vel_y = 32'(vel_out[1]);
        r.new_vel_z = 32'(vel_out[2]);
        return r;
    endfunction

    function automatic particle_t make_particle(logic [23:0] tag,
            logic [31:0] px, logic [31:0] py, logic [31:0] pz,
            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
            logic [31:0] area, logic [31:0] mass);
        particle_t p;
        p.particle_index = tag;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        p.vel_x = vx;
        p.vel_y = vy;
        p.vel_z = vz;
        p.drag_area = area;
        p.body_mass = mass;
        return p;
    endfunction

    function automatic motion_t make_motion(logic [23:0] tag,
            logic [31:0] px, logic [31:0] py, logic [31:0] pz,
            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
            logic grounded, logic saturated, logic zero_mass);
        motion_t m;
        m.tag_out   = tag;
        m.new_pos_x = px;
        m.new_pos_y = py;
        m.new_pos_z = pz;
        m.new_vel_x = vx;
        m.new_vel_y = vy;
        m.new_vel_z = vz;
        m.grounded  = grounded;
        m.saturated = saturated;
        m.zero_mass = zero_mass;
        return m;
    endfunction

    task automatic add_row(particle_t p, bit typed, motion_t want);
        stim_row_t row;
        row.item   = p;
        row.typed  = typed;
        row.result = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // random field values
    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 7))
            0: return corner_value();
            1, 2: return $urandom();
            default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [31:0] random_magnitude();
        case ($urandom_range(0, 7))
            0: return corner_value();
            1: return $urandom();
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    function automatic particle_t random_particle();
        particle_t p;
        p = make_particle(24'($urandom_range(0, 24'hFF_FFFF)), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord(),
                          random_magnitude(), random_magnitude());
        case ($urandom_range(0, 9))
            // raw noise in every field
            0: p = make_particle(24'($urandom()), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            // falling onto the ground
            1, 2: begin
                p.pos_z = $urandom_range(0, 32'h0000_0400);
                p.vel_z = -$urandom_range(0, 32'h0400_0000);
            end
            // rising from below the ground
            3: begin
                p.pos_z = -$urandom_range(0, 32'h0000_0400);
                p.vel_z = $urandom_range(0, 32'h0400_0000);
            end
            // in flight
            default: p.pos_z = $urandom_range(1, 32'h3FFF_FFFF);
        endcase
        if ($urandom_range(0, 11) == 0) p.body_mass = '0;
        return p;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("beat %0d %s got %h want %h", result_count, name, got, want));
    endtask

    task automatic compare_motion(motion_t got, motion_t want);
        check_field("tag_out",   32'(got.tag_out),   32'(want.tag_out));
        check_field("new_pos_x", got.new_pos_x,      want.new_pos_x);
        check_field("new_pos_y", got.new_pos_y,      want.new_pos_y);
        check_field("new_pos_z", got.new_pos_z,      want.new_pos_z);
        check_field("new_vel_x", got.new_vel_x,      want.new_vel_x);
        check_field("new_vel_y", got.new_vel_y,      want.new_vel_y);
        check_field("new_vel_z", got.new_vel_z,      want.new_vel_z);
        check_field("grounded",  32'(got.grounded),  32'(want.grounded));
        check_field("saturated", 32'(got.saturated), 32'(want.saturated));
        check_field("zero_mass", 32'(got.zero_mass), 32'(want.zero_mass));
    endtask

    // offer one particle beat after a random gap, record its result once taken
    task automatic send_particle(particle_t p, bit typed, motion_t want);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        pending_motion.insert(pending_motion.size(), typed ? want : advance_particle(p));
    endtask

    // stop offering and let the pipe empty out
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (pending_motion.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all three registers on consecutive edges
    task automatic load_settings(logic [31:0] dt, logic [31:0] rho, logic [31:0] g);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_STEP_TIME;
        cfg_wdata <= dt;
        @(posedge aclk);
        cfg_addr  <= REG_FLUID_DENSITY;
        cfg_wdata <= rho;
        @(posedge aclk);
        cfg_addr  <= REG_GRAVITY_ACCEL;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_dt  = dt;
        cfg_rho = rho;
        cfg_g   = g;
    endtask

    // result receiver with random and long hold-offs
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            stall = $urandom_range(0, recv_gap_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_motion.size() == 0)
                flag_mismatch($sformatf("beat %0d arrived with no result pending",
                                        result_count));
            else
                compare_motion({m_tuser, m_tdata}, pending_motion.pop_front());
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout");
        $display("FAIL particle_euler_drag_step");
        $finish;
    end

    // stimulus
    initial begin
        // extremes and special cases, run under the reset register values
        add_row(make_particle(24'hFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                make_motion(24'hFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b1));
        add_row(make_particle(24'h00_0001, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0), 1'b1,
                make_motion(24'h00_0001, 0, 0, 32'h0001_0000, 0, 0, 0, 1'b0, 1'b0, 1'b1));
        add_row(make_particle(24'h00_0002, 32'h7FFF_FFFF, 0, 32'h0001_0000,
                              32'h7FFF_FFFF, 0, 0, 0, 0), 1'b1,
                make_motion(24'h00_0002, 32'h7FFF_FFFF, 0, 32'h0001_0000,
                            32'h7FFF_FFFF, 0, 0, 1'b0, 1'b1, 1'b1));
        add_row(make_particle(24'h00_0003, 0, 32'h8000_0000, 32'h0001_0000,
                              0, 32'h8000_0000, 0, 0, 0), 1'b1,
                make_motion(24'h00_0003, 0, 32'h8000_0000, 32'h0001_0000,
                            0, 32'h8000_0000, 0, 1'b0, 1'b1, 1'b1));
        add_row(make_particle(24'h00_0004, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0),
                1'b1, make_motion(24'h00_0004, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF,
                                  1'b0, 1'b1, 1'b1));
        add_row(make_particle(24'h00_0005, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000,
                              0, 32'hFFFF_FFFF), 1'b1,
                make_motion(24'h00_0005, 0, 0, 32'h8000_0000, 0, 0, 0, 1'b1, 1'b1, 1'b0));
        add_row(make_particle(24'h00_0006, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000), 1'b1,
                make_motion(24'h00_0006, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
        // gravity only, one lsb above ground
        add_row(make_particle(24'h00_0007, 0, 0, 32'h0000_0001, 0, 0, 0, 0, 32'h0001_0000),
                1'b0, '0);
        // one lsb above ground, stepping down onto it
        add_row(make_particle(24'h00_0008, 0, 0, 32'h0000_0001, 0, 0, 32'hFFFF_FFFF,
                              32'h0001_0000, 32'h0001_0000), 1'b0, '0);
        // one lsb below ground, climbing out
        add_row(make_particle(24'h00_0009, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF,
                              32'h0001_0000, 32'h0001_0000), 1'b0, '0);
        // ordinary flight with drag
        add_row(make_particle(24'h00_000A, 32'h0001_8000, 32'hFFFD_C000, 32'h0064_0000,
                              32'h0003_0000, 32'hFFFC_0000, 32'h0005_0000,
                              32'h0000_8000, 32'h0002_0000), 1'b0, '0);
        // drag coefficient clamped
        add_row(make_particle(24'h00_000B, 0, 0, 32'h03E8_0000, 32'h0001_0000, 32'hFFFF_0000,
                              32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0001), 1'b0, '0);
        // extreme velocities under heavy drag
        add_row(make_particle(24'h00_000C, 0, 0, 32'h0064_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'hFFFF_FFFF, 32'h0010_0000, 32'h0000_0001), 1'b0, '0);
        // largest area and mass
        add_row(make_particle(24'h00_000D, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0);
        add_row(make_particle(24'h00_000E, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'hFFFF_FFFF, 32'h0000_0001), 1'b0, '0);
        add_row(make_particle(24'h00_000F, 32'h8000_0000, 32'h8000_0000, 32'h0000_0100,
                              32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                              32'h8000_0000, 32'h8000_0000), 1'b0, '0);

        // register settings per random phase
        phase_dt[0] = STEP_TIME_RESET; phase_rho[0] = 32'h0001_0000; phase_g[0] = -32'sd642253;
        phase_dt[1] = '0;              phase_rho[1] = '0;            phase_g[1] = '0;
        phase_dt[2] = 32'hFFFF_FFFF;   phase_rho[2] = 32'hFFFF_FFFF; phase_g[2] = 32'h7FFF_FFFF;
        phase_dt[3] = 32'hFFFF_FFFF;   phase_rho[3] = 32'h0000_0001; phase_g[3] = 32'h8000_0000;
        phase_dt[4] = $urandom();      phase_rho[4] = $urandom();    phase_g[4] = $urandom();
        phase_dt[5] = 32'h1000_0000;   phase_rho[5] = 32'h0004_0000; phase_g[5] = -32'sd642253;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_particle(directed_rows[k].item, directed_rows[k].typed,
                          directed_rows[k].result);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_pipe();
            load_settings(phase_dt[ph], phase_rho[ph], phase_g[ph]);
            send_gap_max = (ph == 2 || ph == 4) ? 0 : 18;
            recv_gap_max = (ph == 1 || ph == 4) ? 0 : 18;
            // back-pressure: receiver holds off while the sender streams
            if (ph == 2) hold_off_cycles = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_particle(random_particle(), 1'b0, '0);
        end
        drain_pipe();

        if (mismatch_count == 0) begin
            $display("PASS particle_euler_drag_step");
        end else begin
            $display("FAIL particle_euler_drag_step");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ped_pkg.sv
hdl/particle_euler_drag_step.sv
dv/particle_euler_drag_step_test.sv
